>>> src/ppoa_pkg.sv
// ----------------------------------------------------------------------------
// ppoa_pkg
// Widths, operation codes and the controller/datapath link types of the POS
// pulse overlap-add block.
// ----------------------------------------------------------------------------
package ppoa_pkg;

  localparam int LEN_W   = 7;
  localparam int AGE_W   = 6;
  localparam int SMP_W   = 16;
  localparam int CNT_W   = 16;
  localparam int PULSE_W = 24;

  localparam int C_W     = 23;
  localparam int S1_W    = 24;
  localparam int S2_W    = 25;
  localparam int SS1_W   = 30;
  localparam int SS2_W   = 31;
  localparam int SQ_W    = 54;
  localparam int V_W     = 64;
  localparam int SD_W    = 32;
  localparam int RATIO_W = 24;
  localparam int HP_W    = 50;
  localparam int H_W     = 36;
  localparam int HS_W    = 42;
  localparam int ACC_W   = 32;

  localparam int CNUM_W  = 40;
  localparam int CDEN_W  = 22;
  localparam int BNUM_W  = 48;
  localparam int BDEN_W  = 32;

  localparam logic [LEN_W-1:0] WINDOW_LEN_RESET = 7'd64;

  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_STORE    = 5'd1;
  localparam logic [4:0] OP_CLR_SUMS = 5'd2;
  localparam logic [4:0] OP_READ     = 5'd3;
  localparam logic [4:0] OP_CH_SUM   = 5'd4;
  localparam logic [4:0] OP_DIV_GO   = 5'd5;
  localparam logic [4:0] OP_S_CALC   = 5'd6;
  localparam logic [4:0] OP_S_SQ     = 5'd7;
  localparam logic [4:0] OP_SQ_ACC   = 5'd8;
  localparam logic [4:0] OP_V        = 5'd9;
  localparam logic [4:0] OP_SQRT_GO  = 5'd10;
  localparam logic [4:0] OP_SD       = 5'd11;
  localparam logic [4:0] OP_RATIO_GO = 5'd12;
  localparam logic [4:0] OP_RATIO    = 5'd13;
  localparam logic [4:0] OP_H_MUL    = 5'd14;
  localparam logic [4:0] OP_H_SUM    = 5'd15;
  localparam logic [4:0] OP_MEAN_GO  = 5'd16;
  localparam logic [4:0] OP_MEAN     = 5'd17;
  localparam logic [4:0] OP_ACC_WR   = 5'd18;
  localparam logic [4:0] OP_EMIT     = 5'd19;
  localparam logic [4:0] OP_CLEAR    = 5'd20;

  typedef struct packed {
    logic [4:0]       op;
    logic [AGE_W-1:0] age;
    logic             sel;
  } cmd_t;

  typedef struct packed {
    logic             cdiv_busy;
    logic             bdiv_busy;
    logic             sqrt_busy;
    logic             out_busy;
    logic             full;
    logic [AGE_W-1:0] avail;
    logic [LEN_W-1:0] len;
  } status_t;

endpackage

>>> src/ppoa_if.sv
// ----------------------------------------------------------------------------
// ppoa_if
// Valid/ready channels of the POS pulse overlap-add block.
// ----------------------------------------------------------------------------
interface ppoa_in_if import ppoa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] red;
  logic [SMP_W-1:0] green;
  logic [SMP_W-1:0] blue;
  logic             last;
  modport source(output valid, red, green, blue, last, input ready);
  modport sink(input valid, red, green, blue, last, output ready);
endinterface

interface ppoa_out_if import ppoa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PULSE_W-1:0] pulse;
  logic                      last_out;
  modport source(output valid, pulse, last_out, input ready);
  modport sink(input valid, pulse, last_out, output ready);
endinterface

interface ppoa_cfg_if import ppoa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] window_len;
  modport source(output valid, window_len, input ready);
  modport sink(input valid, window_len, output ready);
endinterface

>>> src/ppoa_div.sv
// ----------------------------------------------------------------------------
// ppoa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppoa_div import ppoa_pkg::*; #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 22
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_sub;

  assign rem_sh  = {rem, quo[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_q <= den;
      rem   <= '0;
      quo   <= num;
    end else if (busy) begin
      rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

>>> src/ppoa_sqrt.sv
// ----------------------------------------------------------------------------
// ppoa_sqrt
// Digit-by-digit floor square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module ppoa_sqrt import ppoa_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [V_W-1:0]  rad,
  output logic            busy,
  output logic [SD_W-1:0] root
);

  logic [5:0]      cnt;
  logic [V_W-1:0]  rad_q;
  logic [SD_W+1:0] rem;
  logic [SD_W+1:0] rem_sh;
  logic [SD_W+1:0] trial;
  logic            ge;

  assign rem_sh = {rem[SD_W-1:0], rad_q[V_W-1:V_W-2]};
  assign trial  = {root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'(SD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_q <= rad;
      rem   <= '0;
      root  <= '0;
    end else if (busy) begin
      rad_q <= {rad_q[V_W-3:0], 2'b00};
      rem   <= ge ? rem_sh - trial : rem_sh;
      root  <= {root[SD_W-2:0], ge};
    end
  end

endmodule

>>> src/ppoa_dp.sv
// ----------------------------------------------------------------------------
// ppoa_dp
// Datapath: sample ring, projection arithmetic, overlap-add accumulators and
// the result register.
// ----------------------------------------------------------------------------
module ppoa_dp import ppoa_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output status_t          status,
  input  logic [SMP_W-1:0] red,
  input  logic [SMP_W-1:0] green,
  input  logic [SMP_W-1:0] blue,
  ppoa_cfg_if.sink         cfg,
  ppoa_out_if.source       res
);

  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int SW     = AW + 1;
  localparam int ACCV_W = HS_W + 2;
  localparam logic [LEN_W-1:0] MAX_L  = LEN_W'(MAX_WINDOW);
  localparam logic [SW-1:0]    MAX_S  = SW'(MAX_WINDOW);
  localparam logic [SW-1:0]    MAX_M1 = SW'(MAX_WINDOW - 1);
  localparam logic [AW-1:0]    HEAD_LAST = AW'(MAX_WINDOW - 1);

  logic [LEN_W-1:0] window_len;
  logic [LEN_W-1:0] len;
  logic [AW-1:0]    head;
  logic [CNT_W-1:0] count;
  logic [SW-1:0]    slot_raw;
  logic [AW-1:0]    slot;

  logic [3*SMP_W-1:0]     win_mem [MAX_WINDOW];
  logic [S1_W+S2_W-1:0]   s_mem   [MAX_WINDOW];
  logic signed [ACC_W-1:0] acc_mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  acc_valid;

  logic [3*SMP_W-1:0]      win_q;
  logic [S1_W+S2_W-1:0]    s_q;
  logic signed [ACC_W-1:0] acc_rd;
  logic                    acc_vq;
  logic signed [ACC_W-1:0] accv;

  logic [CDEN_W-1:0]  chsum [3];
  logic [SMP_W-1:0]   xv    [3];
  logic [CNUM_W-1:0]  cnum  [3];
  logic [CNUM_W-1:0]  cquo  [3];
  logic [2:0]         cbusy;
  logic signed [S2_W-1:0] ce [3];

  logic signed [S1_W-1:0]   s1_n, s1_r, s1_q;
  logic signed [S2_W-1:0]   s2_n, s2_r, s2_q;
  logic signed [2*S1_W-1:0] p1;
  logic signed [2*S2_W-1:0] p2;
  logic [SQ_W-1:0]          sq1, sq2, sqs1, sqs2, sqsel;
  logic signed [SS1_W-1:0]  sum1;
  logic signed [SS2_W-1:0]  sum2, ssel;
  logic [SS2_W-1:0]         smag;
  logic [V_W-1:0]           va, vb;

  logic             sqrt_busy;
  logic [SD_W-1:0]  root;
  logic [SD_W-1:0]  sd1, sd2;

  logic              bstart;
  logic [BNUM_W-1:0] bnum;
  logic [BDEN_W-1:0] bden;
  logic              bbusy;
  logic [BNUM_W-1:0] bquo;

  logic [RATIO_W-1:0]      ratio;
  logic signed [HP_W-1:0]  hp;
  logic [HP_W-1:0]         hmag;
  logic [HP_W-1:0]         hrnd;
  logic signed [H_W-1:0]   hqe, s1e, h_n, h_r;
  logic signed [HS_W-1:0]  hsum, hmean, qm;
  logic [HS_W-1:0]         hs_mag;
  logic signed [ACCV_W-1:0] v_n;
  logic signed [ACC_W-1:0]  v_sat;
  logic signed [PULSE_W-1:0] pulse_sat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_LEN_RESET;
    end else if (cfg.valid) begin
      window_len <= cfg.window_len;
    end
  end

  always_comb begin
    if (window_len < LEN_W'(2)) begin
      len = LEN_W'(2);
    end else if (window_len > MAX_L) begin
      len = MAX_L;
    end else begin
      len = window_len;
    end
  end

  assign slot_raw = {1'b0, head} + MAX_M1 - SW'(cmd.age[AW-1:0]);
  assign slot     = (slot_raw >= MAX_S) ? AW'(slot_raw - MAX_S) : slot_raw[AW-1:0];

  assign status.cdiv_busy = |cbusy;
  assign status.bdiv_busy = bbusy;
  assign status.sqrt_busy = sqrt_busy;
  assign status.out_busy  = res.valid;
  assign status.full      = count >= CNT_W'(len);
  assign status.avail     = count[AGE_W-1:0];
  assign status.len       = len;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_STORE) begin
      win_mem[head] <= {red, green, blue};
    end
    if (cmd.op == OP_READ) begin
      win_q <= win_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_S_CALC) begin
      s_mem[cmd.age[AW-1:0]] <= {s1_n, s2_n};
    end
    if (cmd.op == OP_READ) begin
      s_q <= s_mem[cmd.age[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACC_WR) begin
      acc_mem[slot] <= v_sat;
    end
    if (cmd.op == OP_READ) begin
      acc_rd <= acc_mem[slot];
      acc_vq <= acc_valid[slot];
    end
  end

  assign accv = acc_vq ? acc_rd : '0;
  assign s1_q = s_q[S1_W+S2_W-1:S2_W];
  assign s2_q = s_q[S2_W-1:0];

  assign xv[0] = win_q[3*SMP_W-1:2*SMP_W];
  assign xv[1] = win_q[2*SMP_W-1:SMP_W];
  assign xv[2] = win_q[SMP_W-1:0];

  for (genvar ch = 0; ch < 3; ch++) begin : g_cdiv
    logic [SMP_W+LEN_W-1:0] xl;
    logic [C_W-1:0]         c;
    assign xl       = xv[ch] * len;
    assign cnum[ch] = CNUM_W'({xl, 16'b0}) + CNUM_W'(chsum[ch] >> 1);
    assign c        = (chsum[ch] == '0) ? '0 : cquo[ch][C_W-1:0];
    assign ce[ch]   = $signed({2'b00, c});

    ppoa_div #(
      .NUM_W(CNUM_W),
      .DEN_W(CDEN_W)
    ) u_cdiv (
      .clk  (clk),
      .rst  (rst),
      .start(cmd.op == OP_DIV_GO),
      .num  (cnum[ch]),
      .den  (chsum[ch]),
      .busy (cbusy[ch]),
      .quo  (cquo[ch])
    );
  end

  assign s1_n = S1_W'(ce[1] - ce[2]);
  assign s2_n = ce[1] + ce[2] - (ce[0] <<< 1);
  assign p1   = s1_r * s1_r;
  assign p2   = s2_r * s2_r;

  assign ssel  = cmd.sel ? sum2 : SS2_W'(sum1);
  assign sqsel = cmd.sel ? sqs2 : sqs1;
  assign smag  = ssel[SS2_W-1] ? SS2_W'(-ssel) : SS2_W'(ssel);

  ppoa_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.op == OP_SQRT_GO),
    .rad  (va - vb),
    .busy (sqrt_busy),
    .root (root)
  );

  assign hs_mag = hsum[HS_W-1] ? HS_W'(-hsum) : HS_W'(hsum);
  assign bstart = (cmd.op == OP_RATIO_GO) || (cmd.op == OP_MEAN_GO);
  assign bnum   = (cmd.op == OP_MEAN_GO) ?
                  BNUM_W'(hs_mag) + BNUM_W'(len >> 1) :
                  BNUM_W'({sd1, 16'b0}) + BNUM_W'(sd2 >> 1);
  assign bden   = (cmd.op == OP_MEAN_GO) ? BDEN_W'(len) : sd2;

  ppoa_div #(
    .NUM_W(BNUM_W),
    .DEN_W(BDEN_W)
  ) u_bdiv (
    .clk  (clk),
    .rst  (rst),
    .start(bstart),
    .num  (bnum),
    .den  (bden),
    .busy (bbusy),
    .quo  (bquo)
  );

  assign hmag = hp[HP_W-1] ? HP_W'(-hp) : HP_W'(hp);
  assign hrnd = hmag + HP_W'(32768);
  assign hqe  = $signed({2'b00, hrnd[HP_W-1:16]});
  assign s1e  = H_W'(s1_q);
  assign h_n  = hp[HP_W-1] ? s1e - hqe : s1e + hqe;
  assign qm   = $signed(bquo[HS_W-1:0]);

  assign v_n = ACCV_W'(accv) + ACCV_W'(h_r) - ACCV_W'(hmean);
  always_comb begin
    if (v_n > ACCV_W'(64'sd2147483647)) begin
      v_sat = 32'sh7FFFFFFF;
    end else if (v_n < -ACCV_W'(64'sd2147483648)) begin
      v_sat = 32'sh80000000;
    end else begin
      v_sat = ACC_W'(v_n);
    end
    if (accv > 32'sd8388607) begin
      pulse_sat = 24'sh7FFFFF;
    end else if (accv < -32'sd8388608) begin
      pulse_sat = 24'sh800000;
    end else begin
      pulse_sat = PULSE_W'(accv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      acc_valid <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_STORE: begin
          acc_valid[head] <= 1'b0;
          head <= (head == HEAD_LAST) ? '0 : head + 1'b1;
          if (count != '1) begin
            count <= count + 1'b1;
          end
        end
        OP_ACC_WR: acc_valid[slot] <= 1'b1;
        OP_EMIT:   res.valid <= 1'b1;
        OP_CLEAR: begin
          acc_valid <= '0;
          head      <= '0;
          count     <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CLR_SUMS: begin
        for (int ch = 0; ch < 3; ch++) begin
          chsum[ch] <= '0;
        end
        sum1 <= '0;
        sum2 <= '0;
        sqs1 <= '0;
        sqs2 <= '0;
        hsum <= '0;
      end
      OP_CH_SUM: begin
        for (int ch = 0; ch < 3; ch++) begin
          chsum[ch] <= chsum[ch] + CDEN_W'(xv[ch]);
        end
      end
      OP_S_CALC: begin
        s1_r <= s1_n;
        s2_r <= s2_n;
      end
      OP_S_SQ: begin
        sq1  <= SQ_W'($unsigned(p1));
        sq2  <= SQ_W'($unsigned(p2));
        sum1 <= sum1 + SS1_W'(s1_r);
        sum2 <= sum2 + SS2_W'(s2_r);
      end
      OP_SQ_ACC: begin
        sqs1 <= sqs1 + sq1;
        sqs2 <= sqs2 + sq2;
      end
      OP_V: begin
        va <= V_W'(len) * V_W'(sqsel);
        vb <= V_W'(smag) * V_W'(smag);
      end
      OP_SD: begin
        if (cmd.sel) begin
          sd2 <= root;
        end else begin
          sd1 <= root;
        end
      end
      OP_RATIO: begin
        if (sd2 == '0) begin
          ratio <= '0;
        end else if (bquo > BNUM_W'(24'hFFFFFF)) begin
          ratio <= '1;
        end else begin
          ratio <= bquo[RATIO_W-1:0];
        end
      end
      OP_H_MUL: hp <= $signed({1'b0, ratio}) * s2_q;
      OP_H_SUM: begin
        h_r  <= h_n;
        hsum <= hsum + HS_W'(h_n);
      end
      OP_MEAN: hmean <= hsum[HS_W-1] ? -qm : qm;
      OP_EMIT: begin
        res.pulse    <= pulse_sat;
        res.last_out <= cmd.sel;
      end
      default: ;
    endcase
  end

endmodule

>>> src/ppoa_ctrl.sv
// ----------------------------------------------------------------------------
// ppoa_ctrl
// Controller: sequences store, projection passes, dividers, square roots and
// result emission for one item at a time.
// ----------------------------------------------------------------------------
module ppoa_ctrl import ppoa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  ppoa_in_if.sink  samples,
  input  status_t  status,
  output cmd_t     cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CHECK   = 5'd1;
  localparam logic [4:0] S_P1_RD   = 5'd2;
  localparam logic [4:0] S_P1_ACC  = 5'd3;
  localparam logic [4:0] S_P2_RD   = 5'd4;
  localparam logic [4:0] S_P2_GO   = 5'd5;
  localparam logic [4:0] S_P2_WAIT = 5'd6;
  localparam logic [4:0] S_P2_S    = 5'd7;
  localparam logic [4:0] S_P2_SQ   = 5'd8;
  localparam logic [4:0] S_P2_ACC  = 5'd9;
  localparam logic [4:0] S_V       = 5'd10;
  localparam logic [4:0] S_SQ_GO   = 5'd11;
  localparam logic [4:0] S_SQ_WAIT = 5'd12;
  localparam logic [4:0] S_SD      = 5'd13;
  localparam logic [4:0] S_R_GO    = 5'd14;
  localparam logic [4:0] S_R_WAIT  = 5'd15;
  localparam logic [4:0] S_R_LATCH = 5'd16;
  localparam logic [4:0] S_P3_RD   = 5'd17;
  localparam logic [4:0] S_P3_MUL  = 5'd18;
  localparam logic [4:0] S_P3_H    = 5'd19;
  localparam logic [4:0] S_M_GO    = 5'd20;
  localparam logic [4:0] S_M_WAIT  = 5'd21;
  localparam logic [4:0] S_M_LATCH = 5'd22;
  localparam logic [4:0] S_P4_RD   = 5'd23;
  localparam logic [4:0] S_P4_MUL  = 5'd24;
  localparam logic [4:0] S_P4_H    = 5'd25;
  localparam logic [4:0] S_P4_WR   = 5'd26;
  localparam logic [4:0] S_E_RD    = 5'd27;
  localparam logic [4:0] S_E_OUT   = 5'd28;
  localparam logic [4:0] S_CLEAR   = 5'd29;

  logic [4:0]       state, state_next;
  logic [AGE_W-1:0] idx, idx_next;
  logic [AGE_W-1:0] e_age, e_age_next;
  logic             sel, sel_next;
  logic             last_r;
  logic             idx_end;
  logic [LEN_W-1:0] len_m1;

  assign samples.ready = (state == S_IDLE);
  assign len_m1        = status.len - 1'b1;
  assign idx_end       = {1'b0, idx} == len_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      idx    <= '0;
      e_age  <= '0;
      sel    <= 1'b0;
      last_r <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      e_age <= e_age_next;
      sel   <= sel_next;
      if (samples.valid && samples.ready) begin
        last_r <= samples.last;
      end
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    e_age_next = e_age;
    sel_next   = sel;
    cmd.op     = OP_NONE;
    cmd.age    = idx;
    cmd.sel    = sel;
    unique case (state)
      S_IDLE: begin
        if (samples.valid) begin
          cmd.op     = OP_STORE;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.op   = OP_CLR_SUMS;
        idx_next = '0;
        sel_next = 1'b0;
        if (status.full) begin
          state_next = S_P1_RD;
        end else if (last_r) begin
          e_age_next = status.avail - 1'b1;
          state_next = S_E_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_P1_RD: begin
        cmd.op     = OP_READ;
        state_next = S_P1_ACC;
      end
      S_P1_ACC: begin
        cmd.op     = OP_CH_SUM;
        idx_next   = idx_end ? '0 : idx + 1'b1;
        state_next = idx_end ? S_P2_RD : S_P1_RD;
      end
      S_P2_RD: begin
        cmd.op     = OP_READ;
        state_next = S_P2_GO;
      end
      S_P2_GO: begin
        cmd.op     = OP_DIV_GO;
        state_next = S_P2_WAIT;
      end
      S_P2_WAIT: begin
        if (!status.cdiv_busy) begin
          state_next = S_P2_S;
        end
      end
      S_P2_S: begin
        cmd.op     = OP_S_CALC;
        state_next = S_P2_SQ;
      end
      S_P2_SQ: begin
        cmd.op     = OP_S_SQ;
        state_next = S_P2_ACC;
      end
      S_P2_ACC: begin
        cmd.op     = OP_SQ_ACC;
        idx_next   = idx_end ? '0 : idx + 1'b1;
        state_next = idx_end ? S_V : S_P2_RD;
      end
      S_V: begin
        cmd.op     = OP_V;
        state_next = S_SQ_GO;
      end
      S_SQ_GO: begin
        cmd.op     = OP_SQRT_GO;
        state_next = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (!status.sqrt_busy) begin
          state_next = S_SD;
        end
      end
      S_SD: begin
        cmd.op     = OP_SD;
        sel_next   = 1'b1;
        state_next = sel ? S_R_GO : S_V;
      end
      S_R_GO: begin
        cmd.op     = OP_RATIO_GO;
        state_next = S_R_WAIT;
      end
      S_R_WAIT: begin
        if (!status.bdiv_busy) begin
          state_next = S_R_LATCH;
        end
      end
      S_R_LATCH: begin
        cmd.op     = OP_RATIO;
        state_next = S_P3_RD;
      end
      S_P3_RD: begin
        cmd.op     = OP_READ;
        state_next = S_P3_MUL;
      end
      S_P3_MUL: begin
        cmd.op     = OP_H_MUL;
        state_next = S_P3_H;
      end
      S_P3_H: begin
        cmd.op     = OP_H_SUM;
        idx_next   = idx_end ? '0 : idx + 1'b1;
        state_next = idx_end ? S_M_GO : S_P3_RD;
      end
      S_M_GO: begin
        cmd.op     = OP_MEAN_GO;
        state_next = S_M_WAIT;
      end
      S_M_WAIT: begin
        if (!status.bdiv_busy) begin
          state_next = S_M_LATCH;
        end
      end
      S_M_LATCH: begin
        cmd.op     = OP_MEAN;
        state_next = S_P4_RD;
      end
      S_P4_RD: begin
        cmd.op     = OP_READ;
        state_next = S_P4_MUL;
      end
      S_P4_MUL: begin
        cmd.op     = OP_H_MUL;
        state_next = S_P4_H;
      end
      S_P4_H: begin
        cmd.op     = OP_H_SUM;
        state_next = S_P4_WR;
      end
      S_P4_WR: begin
        cmd.op   = OP_ACC_WR;
        idx_next = idx_end ? '0 : idx + 1'b1;
        if (idx_end) begin
          e_age_next = len_m1[AGE_W-1:0];
          state_next = S_E_RD;
        end else begin
          state_next = S_P4_RD;
        end
      end
      S_E_RD: begin
        cmd.op     = OP_READ;
        cmd.age    = e_age;
        state_next = S_E_OUT;
      end
      S_E_OUT: begin
        cmd.age = e_age;
        cmd.sel = last_r && (e_age == '0);
        if (!status.out_busy) begin
          cmd.op = OP_EMIT;
          if (!last_r) begin
            state_next = S_IDLE;
          end else if (e_age == '0) begin
            state_next = S_CLEAR;
          end else begin
            e_age_next = e_age - 1'b1;
            state_next = S_E_RD;
          end
        end
      end
      S_CLEAR: begin
        cmd.op     = OP_CLEAR;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/pos_pulse_overlap_add.sv
// ----------------------------------------------------------------------------
// pos_pulse_overlap_add
// POS pulse extraction with overlap-add over a sliding window of RGB means.
// Items are handled one at a time: no new sample is taken until the current
// item is through. Once L samples are held (L = clamped window_len), each item
// runs the bit-serial channel dividers per sample, the 32-step square roots and
// the 48-step ratio and mean divisions; items before the window fills skip the
// projection. Synchronous reset clears control state, ring head, count and
// accumulator flags and sets window_len to 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pos_pulse_overlap_add import ppoa_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input logic        clk,
  input logic        rst,
  ppoa_in_if.sink    samples,
  ppoa_out_if.source results,
  ppoa_cfg_if.sink   cfg
);

  cmd_t    cmd;
  status_t status;

  ppoa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .samples(samples),
    .status (status),
    .cmd    (cmd)
  );

  ppoa_dp #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .status(status),
    .red   (samples.red),
    .green (samples.green),
    .blue  (samples.blue),
    .cfg   (cfg),
    .res   (results)
  );

endmodule
